// ===== design/fhmd_pkg.sv =====
package fhmd_pkg;

    // Sizes of the slot store and the counters.
    localparam int MESH_SLOTS = 64;
    localparam int COUNT_BITS = 32;
    localparam int ADDR_W     = (MESH_SLOTS > 1) ? $clog2(MESH_SLOTS) : 1;

    // Fixed field widths of the items.
    localparam int SLOT_W     = 6;
    localparam int WORD_W     = 32;
    localparam int HASH_W     = 64;
    localparam int OUT_CNT_W  = 32;
    localparam int BYTES      = WORD_W / 8;
    localparam int BYTE_CNT_W = $clog2(BYTES);

    // Offset basis of the running hash (not the standard FNV-1a 64-bit basis).
    localparam logic [HASH_W-1:0] FNV_BASIS = 64'd1469598103934665603;

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [ADDR_W-1:0]     t_addr;

    localparam t_cnt CNT_MAX = '1;

    // One input item.
    typedef struct packed {
        logic [SLOT_W-1:0] mesh_slot;
        logic [WORD_W-1:0] word;
        logic              has_word;
        logic              last_word;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic                 moved;
        logic [OUT_CNT_W-1:0] frames_written;
        logic [OUT_CNT_W-1:0] frames_moved;
        logic                 frozen;
        logic [HASH_W-1:0]    frame_hash;
    } t_out_item;

    // One entry of the per-slot store.
    typedef struct packed {
        logic [HASH_W-1:0] last_hash;
        t_cnt              written;
        t_cnt              moved;
    } t_slot_entry;

    // Control from the sequencer to the hash core.
    typedef struct packed {
        logic              start;
        logic              restart;
        logic [WORD_W-1:0] word;
    } t_hash_ctl;

    // Status from the hash core to the sequencer.
    typedef struct packed {
        logic busy;
        logic last_step;
    } t_hash_sts;

    // One FNV-1a byte step. The prime is 2^40 + 0x1b3, so the product is a
    // sum of shifted copies of the xored hash.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-8){1'b0}}, b};
        fnv_step = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                 + (x << 1) + x;
    endfunction

    // Counter increment that stops at the maximum value.
    function automatic t_cnt sat_inc(input t_cnt c);
        sat_inc = (c == CNT_MAX) ? c : c + t_cnt'(1);
    endfunction

    // Clamp a counter to the width of the result fields.
    function automatic logic [OUT_CNT_W-1:0] clamp_out(input t_cnt c);
        logic over;
        over = (COUNT_BITS > OUT_CNT_W) && (c > t_cnt'({OUT_CNT_W{1'b1}}));
        clamp_out = over ? {OUT_CNT_W{1'b1}} : OUT_CNT_W'(c);
    endfunction

endpackage

// ===== design/fhmd_hash_core.sv =====
module fhmd_hash_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  fhmd_pkg::t_hash_ctl                   i_ctl,
    output fhmd_pkg::t_hash_sts                   o_sts,
    output logic [fhmd_pkg::HASH_W-1:0]           o_hash
);

    logic [fhmd_pkg::HASH_W-1:0]     r_hash;
    logic [fhmd_pkg::WORD_W-1:0]     r_word;
    logic [fhmd_pkg::BYTE_CNT_W-1:0] r_cnt;
    logic                            r_busy;
    logic                            last_step;

    assign last_step = r_busy && (r_cnt == fhmd_pkg::BYTE_CNT_W'(fhmd_pkg::BYTES - 1));

    // Running hash and byte sequencing: one byte is folded in per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= fhmd_pkg::FNV_BASIS;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.restart) begin
                r_hash <= fhmd_pkg::FNV_BASIS;
            end else if (r_busy) begin
                r_hash <= fhmd_pkg::fnv_step(r_hash, r_word[7:0]);
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + fhmd_pkg::BYTE_CNT_W'(1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // The word shifts down so that the next byte is always at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_word <= i_ctl.word;
        end else if (r_busy) begin
            r_word <= r_word >> 8;
        end
    end

    assign o_sts.busy      = r_busy;
    assign o_sts.last_step = last_step;
    assign o_hash          = r_hash;

endmodule

// ===== design/fhmd_slot_mem.sv =====
module fhmd_slot_mem (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  fhmd_pkg::t_addr       i_rd_addr,
    output fhmd_pkg::t_slot_entry o_rd_data,
    input  logic                  i_wr_en,
    input  fhmd_pkg::t_addr       i_wr_addr,
    input  fhmd_pkg::t_slot_entry i_wr_data
);

    fhmd_pkg::t_slot_entry         r_mem [fhmd_pkg::MESH_SLOTS];
    logic [fhmd_pkg::MESH_SLOTS-1:0] r_valid;
    fhmd_pkg::t_slot_entry         r_rd_data;
    logic                          r_rd_valid;

    // Storage array with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // One valid bit per slot; a slot never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== design/frame_hash_motion_detector_unit.sv =====
// Frame hash motion detector.
// Input channel (i_in_valid, o_in_stall, i_in_data): one item carries a
// 32-bit word tagged with a mesh slot. A valid word is folded into a single
// running 64-bit hash by FNV-1a steps, lowest byte first, one byte per cycle.
// Output channel (o_out_valid, i_out_stall, o_out_data): one item for every
// input item that ends a frame, with the final hash, the moved flag, the
// slot's saturating frame counters and the frozen flag.
// The block takes no new item while it works on one: an item with a word
// stays until the byte-serial hash core has folded in all its bytes, and a
// frame-ending item also waits in the finish state until the output
// register is free and its result is loaded there.
// The per-slot store reads in the accept cycle and is written back when
// the result is loaded, so one item at a time touches it.
// Reset clears the running hash to the offset basis, all slot counters and
// seen flags (per-slot valid bits, no clearing pass) and the output register.
// When the receiver stalls, the result waits in the output register; the
// block still takes the next item, and holds at the end of that item's frame
// until the register frees.
module frame_hash_motion_detector_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fhmd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fhmd_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_HASH = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic                        r_last;
    logic                        r_slot_ok;
    fhmd_pkg::t_addr             r_addr;
    logic                        r_out_valid;
    fhmd_pkg::t_out_item         r_out_data;
    fhmd_pkg::t_out_item         n_out_data;

    fhmd_pkg::t_hash_ctl         hash_ctl;
    fhmd_pkg::t_hash_sts         hash_sts;
    logic [fhmd_pkg::HASH_W-1:0] hash;
    fhmd_pkg::t_slot_entry       rd_entry;
    fhmd_pkg::t_slot_entry       wr_entry;
    fhmd_pkg::t_addr             in_addr;
    logic                        in_acc;
    logic                        in_slot_ok;
    logic                        out_free;
    logic                        fin_go;
    logic                        mv;
    fhmd_pkg::t_cnt              new_written;
    fhmd_pkg::t_cnt              new_moved;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign in_addr    = fhmd_pkg::ADDR_W'(i_in_data.mesh_slot);
    assign in_slot_ok = 32'(i_in_data.mesh_slot) < 32'(fhmd_pkg::MESH_SLOTS);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fin_go     = (r_state == S_FIN) && out_free;

    // Sequencer.
    always_comb begin
        n_state          = r_state;
        hash_ctl.start   = 1'b0;
        hash_ctl.restart = 1'b0;
        hash_ctl.word    = i_in_data.word;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    hash_ctl.start = i_in_data.has_word;
                    n_state        = S_HASH;
                end
            end
            S_HASH: begin
                if (!hash_sts.busy || hash_sts.last_step) begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    hash_ctl.restart = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item flags held while the item is worked on.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last    <= i_in_data.last_word;
            r_slot_ok <= in_slot_ok;
            r_addr    <= in_addr;
        end
    end

    fhmd_hash_core u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hash_ctl),
        .o_sts   (hash_sts),
        .o_hash  (hash)
    );

    fhmd_slot_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (fin_go && r_slot_ok),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_entry)
    );

    // Slot update: a slot that was never written reads as zero counters,
    // so a nonzero frame count tells that it has finished a frame before.
    always_comb begin
        mv          = (rd_entry.written != '0) && (hash != rd_entry.last_hash);
        new_written = fhmd_pkg::sat_inc(rd_entry.written);
        new_moved   = mv ? fhmd_pkg::sat_inc(rd_entry.moved) : rd_entry.moved;

        wr_entry.last_hash = hash;
        wr_entry.written   = new_written;
        wr_entry.moved     = new_moved;

        n_out_data.frame_hash = hash;
        if (r_slot_ok) begin
            n_out_data.moved          = mv;
            n_out_data.frames_written = fhmd_pkg::clamp_out(new_written);
            n_out_data.frames_moved   = fhmd_pkg::clamp_out(new_moved);
            n_out_data.frozen         = (new_written > fhmd_pkg::t_cnt'(1))
                                        && (new_moved == '0);
        end else begin
            n_out_data.moved          = 1'b0;
            n_out_data.frames_written = '0;
            n_out_data.frames_moved   = '0;
            n_out_data.frozen         = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/fhmd_checker.sv =====
module fhmd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fhmd_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fhmd_pkg::t_out_item o_out_data
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // While a word is hashed byte by byte, no item is taken.
    a_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.has_word
        |=> o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("item taken while a word is hashed");

    // A moved frame is counted.
    a_moved_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.moved |-> o_out_data.frames_moved != '0)
        else $error("moved frame not counted");

    // Frozen means more than one frame and none moved.
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frozen
        |-> o_out_data.frames_moved == '0 && o_out_data.frames_written > 32'd1)
        else $error("frozen flag inconsistent with counters");

endmodule

bind frame_hash_motion_detector_unit fhmd_checker u_fhmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/sv/tb_frame_hash_motion_detector_unit.sv =====
module tb_frame_hash_motion_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [fhmd_pkg::HASH_W-1:0] FNV_PRIME_64 = 64'd1099511628211;
    localparam int SLOT_SPACE      = 1 << fhmd_pkg::SLOT_W;
    localparam int MAX_BODY        = 6;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_CYCLES = 3000;

    logic                i_clk       = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    fhmd_pkg::t_in_item  in_data     = '0;
    logic                out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    fhmd_pkg::t_out_item o_out_data;

    // Predicted block state.
    logic [fhmd_pkg::HASH_W-1:0] run_hash = fhmd_pkg::FNV_BASIS;
    logic [fhmd_pkg::HASH_W-1:0] slot_hash    [fhmd_pkg::MESH_SLOTS];
    bit                slot_seen    [fhmd_pkg::MESH_SLOTS] = '{default: 1'b0};
    fhmd_pkg::t_cnt    slot_written [fhmd_pkg::MESH_SLOTS] = '{default: '0};
    fhmd_pkg::t_cnt    slot_moved   [fhmd_pkg::MESH_SLOTS] = '{default: '0};
    fhmd_pkg::t_out_item pending_results[$];

    // Last well-formed frame sent per slot, kept so that it can be replayed.
    logic [fhmd_pkg::WORD_W-1:0] frame_buf   [MAX_BODY + 1];
    logic [fhmd_pkg::WORD_W-1:0] saved_words [SLOT_SPACE][MAX_BODY + 1];
    int                saved_len   [SLOT_SPACE];
    bit                saved_tail  [SLOT_SPACE];
    bit                saved_ok    [SLOT_SPACE] = '{default: 1'b0};

    int mismatch_count = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;
    int rx_hold_cycles = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;
    bit rx_hold_req    = 1'b0;
    bit rx_holding     = 1'b0;

    frame_hash_motion_detector_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // FNV-1a over the four bytes of a word, lowest byte first.
    function automatic logic [fhmd_pkg::HASH_W-1:0] fold_word(
            input logic [fhmd_pkg::HASH_W-1:0] h,
            input logic [fhmd_pkg::WORD_W-1:0] w);
        logic [fhmd_pkg::HASH_W-1:0] acc;
        acc = h;
        for (int b = 0; b < fhmd_pkg::BYTES; b++) begin
            acc = acc ^ {{(fhmd_pkg::HASH_W-8){1'b0}}, w[8*b +: 8]};
            acc = acc * FNV_PRIME_64;
        end
        return acc;
    endfunction

    function automatic fhmd_pkg::t_cnt count_up(input fhmd_pkg::t_cnt c);
        return (c == fhmd_pkg::CNT_MAX) ? c : c + fhmd_pkg::t_cnt'(1);
    endfunction

    function automatic logic [fhmd_pkg::OUT_CNT_W-1:0] clamp_count(
            input fhmd_pkg::t_cnt c);
        logic [127:0] wide;
        wide = 128'(c);
        if (wide > 128'({fhmd_pkg::OUT_CNT_W{1'b1}}))
            return {fhmd_pkg::OUT_CNT_W{1'b1}};
        return wide[fhmd_pkg::OUT_CNT_W-1:0];
    endfunction

    // Hot slots half of the time so that slots see many frames.
    function automatic int pick_slot();
        return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
                                           : $urandom_range(0, SLOT_SPACE - 1);
    endfunction

    function automatic logic [fhmd_pkg::WORD_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    // Advance the predicted state by one accepted item.
    task automatic absorb_item(input fhmd_pkg::t_in_item it);
        logic [fhmd_pkg::HASH_W-1:0] h;
        fhmd_pkg::t_out_item r;
        int s;
        h = run_hash;
        if (it.has_word)
            h = fold_word(h, it.word);
        if (!it.last_word) begin
            run_hash = h;
        end else begin
            r = '0;
            r.frame_hash = h;
            s = int'(it.mesh_slot);
            // A slot beyond the store still ends the frame but changes nothing.
            if (s < fhmd_pkg::MESH_SLOTS) begin
                slot_written[s] = count_up(slot_written[s]);
                if (slot_seen[s] && h != slot_hash[s]) begin
                    slot_moved[s] = count_up(slot_moved[s]);
                    r.moved = 1'b1;
                end
                slot_hash[s] = h;
                slot_seen[s] = 1'b1;
                r.frames_written = clamp_count(slot_written[s]);
                r.frames_moved   = clamp_count(slot_moved[s]);
                r.frozen         = (slot_written[s] > fhmd_pkg::t_cnt'(1))
                                   && (slot_moved[s] == '0);
            end
            pending_results.insert(pending_results.size(), r);
            run_hash = fhmd_pkg::FNV_BASIS;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result(input fhmd_pkg::t_out_item got);
        fhmd_pkg::t_out_item want;
        results_seen++;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("result %0d not expected, hash %h",
                                    results_seen, got.frame_hash));
        end else begin
            want = pending_results.pop_front();
            if (got.moved !== want.moved)
                flag_mismatch($sformatf("result %0d moved %b, want %b",
                                        results_seen, got.moved, want.moved));
            if (got.frames_written !== want.frames_written)
                flag_mismatch($sformatf("result %0d frames_written %0d, want %0d",
                              results_seen, got.frames_written, want.frames_written));
            if (got.frames_moved !== want.frames_moved)
                flag_mismatch($sformatf("result %0d frames_moved %0d, want %0d",
                              results_seen, got.frames_moved, want.frames_moved));
            if (got.frozen !== want.frozen)
                flag_mismatch($sformatf("result %0d frozen %b, want %b",
                                        results_seen, got.frozen, want.frozen));
            if (got.frame_hash !== want.frame_hash)
                flag_mismatch($sformatf("result %0d frame_hash %h, want %h",
                              results_seen, got.frame_hash, want.frame_hash));
        end
    endtask

    // Watch both channels: predict on input items, check output items.
    always @(posedge i_clk) begin
        if (rst_n && in_valid && o_in_stall === 1'b0)
            absorb_item(in_data);
        if (rst_n && o_out_valid === 1'b1 && !out_stall)
            check_result(o_out_data);
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold when a test asks for it.
    initial begin
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold_req) begin
                rx_holding = 1'b1;
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_req = 1'b0;
                rx_holding  = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one item and hold it until it is taken. Valid stays high on return.
    task automatic send_item(input int slot, input logic [fhmd_pkg::WORD_W-1:0] w,
                             input bit has, input bit last);
        fhmd_pkg::t_in_item it;
        it.mesh_slot = fhmd_pkg::SLOT_W'(slot);
        it.word      = w;
        it.has_word  = has;
        it.last_word = last;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    // Body words from frame_buf, then the frame-ending item.
    task automatic send_frame(input int slot, input int len, input bit tail,
                              input bit sprinkle);
        for (int k = 0; k < len; k++) begin
            // Items without a word and without an end leave the hash alone.
            if (sprinkle && $urandom_range(0, 5) == 0)
                send_item(pick_slot(), $urandom(), 1'b0, 1'b0);
            send_item(slot, frame_buf[k], 1'b1, 1'b0);
        end
        send_item(slot, frame_buf[len], tail, 1'b1);
    endtask

    task automatic test_directed_cases();
        // Empty frames on the lowest slot: a first frame, then an unchanged one.
        send_item(0, 32'h0000_0000, 1'b0, 1'b1);
        send_item(0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // Extreme words on the highest slot, then the same frame again with an
        // ignored item inside it, then a changed frame.
        send_item(63, 32'h0000_0000, 1'b1, 1'b0);
        send_item(63, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(63, 32'h0000_0000, 1'b1, 1'b0);
        send_item(5, 32'h1234_5678, 1'b0, 1'b0);
        send_item(63, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(63, 32'h0000_0000, 1'b1, 1'b0);
        send_item(63, 32'hFFFF_FFFE, 1'b1, 1'b1);
        // Words of two slots mix into the one running hash.
        send_item(10, 32'hA5A5_5A5A, 1'b1, 1'b0);
        send_item(20, 32'h5A5A_A5A5, 1'b1, 1'b0);
        send_item(20, 32'h0000_0001, 1'b1, 1'b1);
        // Frames that differ from the stored hash count as moved.
        send_item(0, 32'h8000_0000, 1'b1, 1'b1);
        send_item(20, 32'h0000_0000, 1'b0, 1'b1);
        send_item(63, 32'h0000_0000, 1'b0, 1'b1);
    endtask

    // Mostly well-formed frames, new or replayed, plus interleaved and noise items.
    task automatic test_random_frames(input int n_items);
        int target;
        int r;
        int slot;
        int len;
        bit tail;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                slot = pick_slot();
                if (saved_ok[slot] && $urandom_range(0, 1) == 0) begin
                    len  = saved_len[slot];
                    tail = saved_tail[slot];
                    for (int k = 0; k <= MAX_BODY; k++)
                        frame_buf[k] = saved_words[slot][k];
                end else begin
                    len  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_BODY);
                    tail = 1'($urandom_range(0, 1));
                    for (int k = 0; k <= MAX_BODY; k++)
                        frame_buf[k] = rand_word();
                end
                send_frame(slot, len, tail, 1'($urandom_range(0, 1)));
                for (int k = 0; k <= MAX_BODY; k++)
                    saved_words[slot][k] = frame_buf[k];
                saved_len[slot]  = len;
                saved_tail[slot] = tail;
                saved_ok[slot]   = 1'b1;
            end else if (r < 85) begin
                // Words tagged with random slots, ended on a randomly picked slot.
                repeat ($urandom_range(1, 3))
                    send_item(pick_slot(), rand_word(), 1'b1, 1'b0);
                send_item(pick_slot(), rand_word(), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                send_item($urandom_range(0, SLOT_SPACE - 1), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering frame-ending items.
    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        in_valid <= 1'b0;
        rx_hold_cycles = 250;
        rx_hold_req = 1'b1;
        wait (rx_holding);
        @(posedge i_clk);
        repeat (30)
            send_item(pick_slot(), rand_word(), 1'b1, 1'b1);
        tx_idle_on = 1'b1;
    endtask

    task automatic test_streaming_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_frames(250);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_frames(850);
        test_output_backpressure();
        test_random_frames(550);
        test_streaming_no_idle();

        // Drain: every expected result must arrive, then a short settle.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== frame_hash_motion_detector_unit.f =====
design/fhmd_pkg.sv
design/fhmd_hash_core.sv
design/fhmd_slot_mem.sv
design/frame_hash_motion_detector_unit.sv
design/fhmd_checker.sv
tb/sv/tb_frame_hash_motion_detector_unit.sv
